@@ rtl/i2r_pkg.sv @@
// Shared types, letter tables and spelling helpers for the Roman numeral converter.
package i2r_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ADDITIVE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOWER    = 8'd1;

  localparam logic [11:0] MAX_VALUE = 12'd3999;
  localparam int unsigned Thousand  = 1000;
  localparam int unsigned Hundred   = 100;
  localparam int unsigned Ten       = 10;

  localparam logic [7:0] LOWER_BIT = 8'h20;

  // Letters by emit position: thousands, hundreds, tens, units.
  localparam logic [7:0] ONE_LETTER  [4] = '{8'h4D, 8'h43, 8'h58, 8'h49}; // M C X I
  localparam logic [7:0] FIVE_LETTER [4] = '{8'h00, 8'h44, 8'h4C, 8'h56}; // - D L V
  localparam logic [7:0] TEN_LETTER  [4] = '{8'h00, 8'h4D, 8'h43, 8'h58}; // - M C X

  // Decoded item: dig[0] thousands .. dig[3] units.
  typedef struct packed {
    logic            empty;
    logic [3:0][3:0] dig;
  } i2r_item_t;

  // Number of letters one digit spells.
  function automatic logic [2:0] digit_len(input logic [3:0] d, input logic additive,
                                           input logic is_thousands);
    logic [2:0] len;
    if (is_thousands) begin
      len = d[2:0];
    end else if (!additive && (d == 4'd4 || d == 4'd9)) begin
      len = 3'd2;
    end else if (d >= 4'd5) begin
      len = 3'(d - 4'd4);
    end else begin
      len = d[2:0];
    end
    return len;
  endfunction

endpackage

@@ rtl/i2r_front.sv @@
// Front end: accepts values, checks range and splits them into decimal digits.
module i2r_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [11:0]         value,
  output logic                push,
  input  logic                q_full,
  output i2r_pkg::i2r_item_t  item
);

  logic        a_valid;
  logic        a_empty;
  logic [1:0]  a_th;
  logic [9:0]  a_r1;
  logic        b_valid;
  logic        b_empty;
  logic [1:0]  b_th;
  logic [3:0]  b_h;
  logic [6:0]  b_r2;

  logic        b_ready;
  logic        a_load;
  logic [1:0]  th_next;
  logic [3:0]  h_next;
  logic [3:0]  t_cur;
  logic [3:0]  u_cur;

  assign push     = b_valid && !q_full;
  assign b_ready  = !b_valid || !q_full;
  assign in_ready = !a_valid || b_ready;
  assign a_load   = in_valid && in_ready;

  always_comb begin
    th_next = 2'd0;
    for (int i = 1; i <= 3; i++) begin
      if (value >= 12'(i * i2r_pkg::Thousand)) th_next = 2'(i);
    end
  end

  always_comb begin
    h_next = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (a_r1 >= 10'(i * i2r_pkg::Hundred)) h_next = 4'(i);
    end
  end

  always_comb begin
    t_cur = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (b_r2 >= 7'(i * i2r_pkg::Ten)) t_cur = 4'(i);
    end
    u_cur = 4'(b_r2 - 7'(t_cur) * 7'(i2r_pkg::Ten));
  end

  always_comb begin
    item.empty  = b_empty;
    item.dig[0] = {2'b00, b_th};
    item.dig[1] = b_h;
    item.dig[2] = t_cur;
    item.dig[3] = u_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (b_ready)  b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_empty <= (value == 12'd0) || (value > i2r_pkg::MAX_VALUE);
      a_th    <= th_next;
      a_r1    <= 10'(value - 12'(th_next) * 12'(i2r_pkg::Thousand));
    end
    if (b_ready && a_valid) begin
      b_empty <= a_empty;
      b_th    <= a_th;
      b_h     <= h_next;
      b_r2    <= 7'(a_r1 - 10'(h_next) * 10'(i2r_pkg::Hundred));
    end
  end

endmodule

@@ rtl/i2r_fifo.sv @@
// Short queue of decoded items between front end and letter sequencer.
module i2r_fifo #(
  parameter int unsigned DEPTH = 4  // 2 or more
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2r_pkg::i2r_item_t  wr_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output i2r_pkg::i2r_item_t  head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  i2r_pkg::i2r_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count overflow");

endmodule

@@ rtl/i2r_back.sv @@
// Letter sequencer: walks the digits of one item and emits one letter per cycle while m_tready lets the output move.
module i2r_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  i2r_pkg::i2r_item_t  head,
  output logic                pop,
  input  logic                additive,
  input  logic                lower,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  logic               busy;
  i2r_pkg::i2r_item_t cur;
  logic [1:0]         pos;
  logic [2:0]         k;

  logic [2:0] len_c [4];
  logic [3:0] nz_c;
  logic [3:0] nz_h;
  logic [3:0] later;
  logic       has_later;
  logic [1:0] next_pos;
  logic [1:0] start_pos;
  logic       dig_end;
  logic       item_end;
  logic       adv;
  logic       emit;
  logic [3:0] d;
  logic [7:0] letter;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      len_c[p] = i2r_pkg::digit_len(cur.dig[p], additive, p == 0);
      nz_c[p]  = (len_c[p] != 3'd0);
      nz_h[p]  = (i2r_pkg::digit_len(head.dig[p], additive, p == 0) != 3'd0);
      later[p] = nz_c[p] && (2'(p) > pos);
    end
    has_later = |later;
    next_pos  = 2'd3;
    start_pos = 2'd3;
    for (int p = 3; p >= 0; p--) begin
      if (later[p]) next_pos = 2'(p);
      if (nz_h[p])  start_pos = 2'(p);
    end
  end

  assign dig_end  = (3'(k + 3'd1) == len_c[pos]);
  assign item_end = cur.empty || (dig_end && !has_later);
  assign adv      = !m_tvalid || m_tready;
  assign emit     = busy && adv;
  assign pop      = head_valid && (!busy || (emit && item_end));
  assign d        = cur.dig[pos];

  always_comb begin
    letter = i2r_pkg::ONE_LETTER[pos];
    if (pos != 2'd0) begin
      if (!additive && d == 4'd4) begin
        if (k != 3'd0) letter = i2r_pkg::FIVE_LETTER[pos];
      end else if (!additive && d == 4'd9) begin
        if (k != 3'd0) letter = i2r_pkg::TEN_LETTER[pos];
      end else if (d >= 4'd5) begin
        if (k == 3'd0) letter = i2r_pkg::FIVE_LETTER[pos];
      end
    end
    if (lower) letter = letter | i2r_pkg::LOWER_BIT;
    if (cur.empty) letter = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      pos      <= 2'd0;
      k        <= 3'd0;
    end else begin
      if (adv) m_tvalid <= busy;
      if (emit && !item_end) begin
        if (dig_end) begin
          pos <= next_pos;
          k   <= 3'd0;
        end else begin
          k <= k + 3'd1;
        end
      end
      if (pop) begin
        busy <= 1'b1;
        pos  <= start_pos;
        k    <= 3'd0;
      end else if (emit && item_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (emit) begin
      m_tdata <= letter;
      m_tlast <= item_end;
      m_tuser <= cur.empty;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast)
    else $error("empty result without last flag");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && m_tuser) |-> (m_tdata == 8'h00))
    else $error("empty result carries a letter");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tuser) |-> (m_tdata != 8'h00))
    else $error("numeral letter is zero");
  assert property (@(posedge clk) disable iff (rst)
                   (busy && !cur.empty) |-> (k < len_c[pos]))
    else $error("letter index past end of digit");

endmodule

@@ rtl/integer_to_roman_numeral_top.sv @@
// Top level of the integer to Roman numeral converter.
// Usage:
//   s_* channel takes one value per item (s_tdata[11:0]). m_* channel returns
//   the numeral as a run of ASCII letters, one letter per item, m_tlast on the
//   final letter. A value of 0 or above 3999 returns a single item with
//   m_tdata 0 and m_tuser and m_tlast set.
//   cfg_* writes a register: index 0 selects the additive long form (bit 0),
//   index 1 selects lower case (bit 0); other indexes are ignored. cfg_ready
//   is always high; write only while no conversion is in flight.
// The first letter of a value passes the two digit split stages, the queue,
//   the sequencer load and the output register.
// Throughput: one letter per cycle while m_tready is high; a numeral has
//   1 to 18 letters. The letter sequencer, which walks one letter of one
//   digit per cycle, sets this. Items follow
//   one another with no gap while the queue holds work.
// Reset clears the pipeline, the queue and both registers (short form,
//   upper case). When m_tready is low the output item holds, the queue fills
//   behind it, and s_tready drops once the front stages are full too.
module integer_to_roman_numeral_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [11:0] value, [15:12] zero
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] letter
  output logic                              m_tlast,
  output logic                              m_tuser,   // [0] empty_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2r_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2r_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic               additive_mode;
  logic               lower_case;
  logic               push;
  logic               q_full;
  logic               pop;
  logic               head_valid;
  i2r_pkg::i2r_item_t wr_item;
  i2r_pkg::i2r_item_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      additive_mode <= 1'b0;
      lower_case    <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == i2r_pkg::CFG_IDX_ADDITIVE) additive_mode <= cfg_data[0];
      if (cfg_index == i2r_pkg::CFG_IDX_LOWER)    lower_case    <= cfg_data[0];
    end
  end

  i2r_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .value    (s_tdata[11:0]),
    .push     (push),
    .q_full   (q_full),
    .item     (wr_item)
  );

  i2r_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_item    (wr_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  i2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .additive   (additive_mode),
    .lower      (lower_case),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

@@ tb/sv/integer_to_roman_numeral_top_test.sv @@
// Self-checking bench for the Roman numeral converter: directed values, then random phases.
module integer_to_roman_numeral_top_test;

  typedef struct packed {
    logic [7:0] letter;
    logic       last;
    logic       empty;
  } roman_letter_t;

  typedef struct packed {
    logic [11:0]   value;
    logic          typed;
    roman_letter_t want;
  } directed_row_t;

  localparam roman_letter_t EMPTY_ITEM = '{8'h00, 1'b1, 1'b1};
  localparam logic [7:0] CFG_IDX_UNUSED = 8'd2;
  localparam logic [7:0] CFG_IDX_TOP    = 8'hFF;
  localparam logic [7:0] CASE_BIT       = 8'h20;

  // Letters per digit position: units, tens, hundreds.
  localparam logic [7:0] ONE_CH  [3] = '{"I", "X", "C"};
  localparam logic [7:0] FIVE_CH [3] = '{"V", "L", "D"};
  localparam logic [7:0] TEN_CH  [3] = '{"X", "C", "M"};
  localparam int unsigned DIGIT_SCALE [3] = '{1, 10, 100};
  // Digits that spell the longest or the subtractive forms.
  localparam int unsigned HARD_DIGIT [4] = '{3, 4, 8, 9};

  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 24;
  localparam int RUN_LIMIT    = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [i2r_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [i2r_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  integer_to_roman_numeral_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  roman_letter_t pending_letters [$];
  logic          add_mode;
  logic          lower_mode;
  int            send_idle;
  int            rcv_idle;
  logic          rcv_hold = 1'b0;
  bit            hold_req = 1'b0;
  int            mismatches = 0;
  int            values_sent = 0;
  int            letters_seen = 0;
  roman_letter_t got_item;
  roman_letter_t want_item;

  directed_row_t dir_rows [25] = '{
    '{12'd0,    1'b1, EMPTY_ITEM},
    '{12'd1,    1'b1, '{"I", 1'b1, 1'b0}},
    '{12'd4095, 1'b1, EMPTY_ITEM},
    '{12'd4000, 1'b1, EMPTY_ITEM},
    '{12'd3999, 1'b0, '0},
    '{12'd3998, 1'b0, '0},
    '{12'd2,    1'b0, '0},
    '{12'd3,    1'b0, '0},
    '{12'd4,    1'b0, '0},
    '{12'd5,    1'b0, '0},
    '{12'd9,    1'b0, '0},
    '{12'd10,   1'b0, '0},
    '{12'd14,   1'b0, '0},
    '{12'd19,   1'b0, '0},
    '{12'd40,   1'b0, '0},
    '{12'd50,   1'b0, '0},
    '{12'd90,   1'b0, '0},
    '{12'd400,  1'b0, '0},
    '{12'd444,  1'b0, '0},
    '{12'd500,  1'b0, '0},
    '{12'd900,  1'b0, '0},
    '{12'd1000, 1'b0, '0},
    '{12'd1994, 1'b0, '0},
    '{12'd2730, 1'b0, '0},
    '{12'd1365, 1'b0, '0}
  };

  function automatic roman_letter_t letter_item(input logic [7:0] ch);
    roman_letter_t it;
    it.letter = lower_mode ? (ch | CASE_BIT) : ch;
    it.last   = 1'b0;
    it.empty  = 1'b0;
    return it;
  endfunction

  // Expected letters of one value under the current mode and case.
  function automatic void spell_numeral(input logic [11:0] v);
    roman_letter_t word [$];
    int unsigned   rest;
    int unsigned   d;
    int            pos;
    if (v == 12'd0 || v > i2r_pkg::MAX_VALUE) begin
      pending_letters.push_back(EMPTY_ITEM);
      return;
    end
    repeat (v / 1000) word.push_back(letter_item("M"));
    rest = v % 1000;
    for (pos = 2; pos >= 0; pos--) begin
      d = (rest / DIGIT_SCALE[pos]) % 10;
      if (!add_mode && d == 4) begin
        word.push_back(letter_item(ONE_CH[pos]));
        word.push_back(letter_item(FIVE_CH[pos]));
      end else if (!add_mode && d == 9) begin
        word.push_back(letter_item(ONE_CH[pos]));
        word.push_back(letter_item(TEN_CH[pos]));
      end else begin
        if (d >= 5) begin
          word.push_back(letter_item(FIVE_CH[pos]));
          d = d - 5;
        end
        repeat (d) word.push_back(letter_item(ONE_CH[pos]));
      end
    end
    word[word.size() - 1].last = 1'b1;
    foreach (word[k]) pending_letters.push_back(word[k]);
  endfunction

  function automatic void apply_reg(input logic [7:0] idx, input logic [7:0] data);
    if (idx == i2r_pkg::CFG_IDX_ADDITIVE) begin
      add_mode = data[0];
    end else if (idx == i2r_pkg::CFG_IDX_LOWER) begin
      lower_mode = data[0];
    end
  endfunction

  // Writes both registers plus two ignored indexes; upper data bits are noise.
  task automatic write_regs(input logic add, input logic lower);
    logic [7:0] idx [4];
    logic [7:0] dat [4];
    idx = '{CFG_IDX_UNUSED, i2r_pkg::CFG_IDX_ADDITIVE, i2r_pkg::CFG_IDX_LOWER, CFG_IDX_TOP};
    dat = '{8'($urandom), {7'($urandom), add}, {7'($urandom), lower}, 8'($urandom)};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], dat[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_value(input logic [11:0] v, input bit drain_first, input logic typed,
                            input roman_letter_t typed_item);
    bit lowered;
    lowered = 1'b0;
    if (drain_first) begin
      s_tvalid <= 1'b0;
      lowered = 1'b1;
      do @(posedge clk); while (pending_letters.size() != 0);
    end
    while ($urandom_range(99) < send_idle) begin
      if (!lowered) begin
        s_tvalid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, v};
    do @(posedge clk); while (!s_tready);
    values_sent++;
    if (typed) begin
      pending_letters.push_back(typed_item);
    end else begin
      spell_numeral(v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_item = '{m_tdata, m_tlast, m_tuser};
      letters_seen++;
      if (pending_letters.size() == 0) begin
        $display("%0t: unexpected item letter=%h last=%b empty=%b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatches++;
      end else begin
        want_item = pending_letters.pop_front();
        if (got_item !== want_item) begin
          $display("%0t: expected letter=%h last=%b empty=%b, got letter=%h last=%b empty=%b",
                   $time, want_item.letter, want_item.last, want_item.empty,
                   got_item.letter, got_item.last, got_item.empty);
          mismatches++;
        end
      end
    end
    m_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
  end

  // Long output stall on request, so the queue fills and s_tready drops.
  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk);
      rcv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rcv_hold <= 1'b0;
      hold_req = 1'b0;
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic [11:0] v;
    logic [1:0]  phase_cfg;
    add_mode   = 1'b0;
    lower_mode = 1'b0;
    send_idle  = 35;
    rcv_idle   = 52;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) send_value(dir_rows[r].value, 1'b0, dir_rows[r].typed, dir_rows[r].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (pending_letters.size() != 0);
      phase_cfg = (p < 4) ? 2'(p) : 2'($urandom);
      write_regs(phase_cfg[0], phase_cfg[1]);
      if (p < 2) begin
        send_idle = 35;
        rcv_idle  = 52;
      end else if (p < 4) begin
        send_idle = 52;
        rcv_idle  = 35;
      end else begin
        send_idle = 0;
        rcv_idle  = 0;
      end
      if (p == 1) hold_req = 1'b1;
      // largest value first in every setting
      send_value(12'd3999, 1'b0, 1'b0, EMPTY_ITEM);
      for (int i = 1; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          v = 12'd0;
        end else if (pick < 12) begin
          v = 12'($urandom_range(4095, 4000));
        end else if (pick < 35) begin
          v = 12'($urandom_range(3, 0) * 1000 + HARD_DIGIT[$urandom_range(3, 0)] * 100 +
                  HARD_DIGIT[$urandom_range(3, 0)] * 10 + HARD_DIGIT[$urandom_range(3, 0)]);
        end else begin
          v = 12'($urandom_range(3999, 1));
        end
        send_value(v, (p == 3 && i == 20), 1'b0, EMPTY_ITEM);
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_letters.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d letters over %0d register settings",
             values_sent, letters_seen, NUM_PHASES + 1);
    $display("Short and long form, both cases, out-of-range values, a %0d-cycle stall",
             HOLD_CYCLES);
    if (mismatches == 0 && pending_letters.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
